// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers used by the controller RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/psacl_pkg.sv -----
package psacl_pkg;

  localparam logic [2:0] OP_FRAME      = 3'd0;
  localparam logic [2:0] OP_BLOCK_ADD  = 3'd1;
  localparam logic [2:0] OP_BLOCK_REM  = 3'd2;
  localparam logic [2:0] OP_PORT_ADD   = 3'd3;
  localparam logic [2:0] OP_PORT_REM   = 3'd4;
  localparam logic [2:0] OP_ALLOW_ADD  = 3'd5;
  localparam logic [2:0] OP_ALLOW_REM  = 3'd6;
  localparam logic [2:0] OP_UNUSED     = 3'd7;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_ABSENT = 2'd2;

  localparam logic [1:0] TBL_BLOCK = 2'd0;
  localparam logic [1:0] TBL_PORT  = 2'd1;
  localparam logic [1:0] TBL_ALLOW = 2'd2;

  localparam logic [15:0] KIND_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP = 8'd6;
  localparam logic [5:0]  ETH_MIN   = 6'd14;
  localparam logic [5:0]  IP_MIN    = 6'd34;
  localparam logic [5:0]  TCP_MIN   = 6'd54;
  localparam logic [5:0]  POS_MAX   = 6'd63;

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  frame_byte;
    logic        frame_end;
    logic [31:0] ip_address;
    logic [15:0] tcp_port;
  } in_item_t;

  typedef struct packed {
    logic       result_kind;
    logic       verdict;
    logic [1:0] table_status;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic       scan_start;  // reset scan pointer, begin search
    logic [1:0] tbl;         // table being scanned
    logic       key_frame;   // key from captured header instead of item
    logic       do_insert;   // write found free slot
    logic       do_remove;   // clear matched slot
    logic       clear_step;  // clear sweep write
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;
    logic hit;
    logic free_found;
    logic clear_done;
  } dp_stat_t;

endpackage

// ----- hw/rtl/psacl_datapath.sv -----
module psacl_datapath import psacl_pkg::*; #(
  parameter int BLOCK_ENTRIES = 1024,
  parameter int PORT_ENTRIES  = 256,
  parameter int ALLOW_ENTRIES = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  dp_cmd_t     cmd,
  input  logic [31:0] key_addr,
  input  logic [15:0] key_port,
  input  logic [31:0] frm_addr,
  input  logic [15:0] frm_port,
  output dp_stat_t    stat
);
  localparam int MAXN = (BLOCK_ENTRIES > ALLOW_ENTRIES) ?
                        ((BLOCK_ENTRIES > PORT_ENTRIES) ? BLOCK_ENTRIES : PORT_ENTRIES) :
                        ((ALLOW_ENTRIES > PORT_ENTRIES) ? ALLOW_ENTRIES : PORT_ENTRIES);
  localparam int PW = $clog2(MAXN + 1);
  localparam int BAW = (BLOCK_ENTRIES > 1) ? $clog2(BLOCK_ENTRIES) : 1;
  localparam int PAW = (PORT_ENTRIES > 1) ? $clog2(PORT_ENTRIES) : 1;
  localparam int AAW = (ALLOW_ENTRIES > 1) ? $clog2(ALLOW_ENTRIES) : 1;

  logic [32:0] blk_mem [BLOCK_ENTRIES];
  logic [16:0] prt_mem [PORT_ENTRIES];
  logic [48:0] alw_mem [ALLOW_ENTRIES];

  // scan: rd_ptr issues reads, cmp_ptr tags registered data
  logic [PW-1:0] rd_ptr, cmp_ptr, free_idx;
  logic          cmp_vld, free_found, hit, scan_done, scanning;
  logic [PW-1:0] hit_idx;
  logic [32:0]   blk_q;
  logic [16:0]   prt_q;
  logic [48:0]   alw_q;
  logic [31:0]   k_addr;
  logic [15:0]   k_port;
  logic [PW-1:0] tbl_n;
  logic          entry_valid, entry_match;

  assign k_addr = cmd.key_frame ? frm_addr : key_addr;
  assign k_port = cmd.key_frame ? frm_port : key_port;

  always_comb begin
    case (cmd.tbl)
      TBL_BLOCK: tbl_n = PW'(BLOCK_ENTRIES);
      TBL_PORT:  tbl_n = PW'(PORT_ENTRIES);
      default:   tbl_n = PW'(ALLOW_ENTRIES);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_ptr < PW'(BLOCK_ENTRIES)) blk_q <= blk_mem[rd_ptr[BAW-1:0]];
    if (rd_ptr < PW'(PORT_ENTRIES))  prt_q <= prt_mem[rd_ptr[PAW-1:0]];
    if (rd_ptr < PW'(ALLOW_ENTRIES)) alw_q <= alw_mem[rd_ptr[AAW-1:0]];
  end

  always_comb begin
    case (cmd.tbl)
      TBL_BLOCK: begin
        entry_valid = blk_q[32];
        entry_match = blk_q[32] && blk_q[31:0] == k_addr;
      end
      TBL_PORT: begin
        entry_valid = prt_q[16];
        entry_match = prt_q[16] && prt_q[15:0] == k_port;
      end
      default: begin
        entry_valid = alw_q[48];
        entry_match = alw_q[48] && alw_q[47:32] == k_port && alw_q[31:0] == k_addr;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scanning <= 1'b0; cmp_vld <= 1'b0; scan_done <= 1'b0;
      hit <= 1'b0; free_found <= 1'b0; rd_ptr <= '0;
    end else if (cmd.scan_start) begin
      scanning <= 1'b1; cmp_vld <= 1'b0; scan_done <= 1'b0;
      hit <= 1'b0; free_found <= 1'b0; rd_ptr <= '0;
    end else if (cmd.clear_step) begin
      rd_ptr <= rd_ptr + 1'b1;
    end else if (scanning) begin
      cmp_vld <= rd_ptr < tbl_n;
      cmp_ptr <= rd_ptr;
      if (rd_ptr < tbl_n) rd_ptr <= rd_ptr + 1'b1;
      if (cmp_vld) begin
        if (entry_match && !hit) begin
          hit <= 1'b1; hit_idx <= cmp_ptr;
        end
        if (!entry_valid && !free_found) begin
          free_found <= 1'b1; free_idx <= cmp_ptr;
        end
      end
      if (cmp_vld && (cmp_ptr == tbl_n - 1'b1 || entry_match)) begin
        scanning <= 1'b0; scan_done <= 1'b1;
      end
    end else if (cmd.do_insert || cmd.do_remove) begin
      scan_done <= 1'b0;
    end
  end

  // writes: clear sweep, insert, remove
  always_ff @(posedge clk) begin
    if (cmd.clear_step) begin
      if (rd_ptr < PW'(BLOCK_ENTRIES)) blk_mem[rd_ptr[BAW-1:0]] <= '0;
      if (rd_ptr < PW'(PORT_ENTRIES))  prt_mem[rd_ptr[PAW-1:0]] <= '0;
      if (rd_ptr < PW'(ALLOW_ENTRIES)) alw_mem[rd_ptr[AAW-1:0]] <= '0;
    end else if (cmd.do_insert) begin
      case (cmd.tbl)
        TBL_BLOCK: blk_mem[free_idx[BAW-1:0]] <= {1'b1, k_addr};
        TBL_PORT:  prt_mem[free_idx[PAW-1:0]] <= {1'b1, k_port};
        default:   alw_mem[free_idx[AAW-1:0]] <= {1'b1, k_port, k_addr};
      endcase
    end else if (cmd.do_remove) begin
      case (cmd.tbl)
        TBL_BLOCK: blk_mem[hit_idx[BAW-1:0]] <= '0;
        TBL_PORT:  prt_mem[hit_idx[PAW-1:0]] <= '0;
        default:   alw_mem[hit_idx[AAW-1:0]] <= '0;
      endcase
    end
  end

  assign stat.scan_done  = scan_done;
  assign stat.hit        = hit;
  assign stat.free_found = free_found;
  assign stat.clear_done = rd_ptr >= PW'(MAXN - 1);
endmodule

// ----- hw/rtl/psacl_controller.sv -----
module psacl_controller import psacl_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  in_item_t  item,
  input  dp_stat_t  stat,
  output logic      busy,
  output dp_cmd_t   cmd,
  output logic [31:0] key_addr,
  output logic [15:0] key_port,
  output logic [31:0] frm_addr,
  output logic [15:0] frm_port,
  output logic      result_strobe,
  output out_item_t result
);
  `include "assert_macros.svh"

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_KICK  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_WRITE = 3'd4;

  logic [2:0]  state;
  logic [5:0]  byte_position;
  logic [15:0] ether_kind;
  logic [7:0]  ip_protocol;
  logic [31:0] source_address;
  logic [15:0] destination_port;
  logic [2:0]  cur_op;
  logic [1:0]  tbl;
  logic        key_frame;
  logic        frame_len_tcp;   // frame long enough for port checks
  logic        acc;
  logic [5:0]  pos;
  logic        decide_now;

  assign acc = start && !busy;
  assign busy = state != S_IDLE;
  assign frm_addr = source_address;
  assign frm_port = destination_port;
  assign pos = byte_position;

  always_comb begin
    cmd = '0;
    cmd.tbl = tbl;
    cmd.key_frame = key_frame;
    cmd.clear_step = state == S_CLEAR;
    cmd.scan_start = state == S_KICK;
    if (state == S_WRITE) begin
      cmd.do_insert = (cur_op == OP_BLOCK_ADD || cur_op == OP_PORT_ADD ||
                       cur_op == OP_ALLOW_ADD) && !stat.hit && stat.free_found;
      cmd.do_remove = (cur_op == OP_BLOCK_REM || cur_op == OP_PORT_REM ||
                       cur_op == OP_ALLOW_REM) && stat.hit;
    end
  end

  // verdict known after the finished scan of the current table
  always_comb begin
    case (tbl)
      TBL_BLOCK: decide_now = stat.hit || ip_protocol != PROTO_TCP || !frame_len_tcp;
      TBL_PORT:  decide_now = !stat.hit;
      default:   decide_now = 1'b1;
    endcase
  end

  // full header seen at end byte (captures for current byte folded in)
  logic [15:0] ek_n;
  logic [7:0]  pr_n;
  logic [31:0] sa_n;
  logic [15:0] dp_n;
  always_comb begin
    ek_n = ether_kind; pr_n = ip_protocol; sa_n = source_address; dp_n = destination_port;
    if (pos == 6'd12 || pos == 6'd13) ek_n = {ether_kind[7:0], item.frame_byte};
    else if (pos == 6'd23) pr_n = item.frame_byte;
    else if (pos >= 6'd26 && pos <= 6'd29) sa_n = {source_address[23:0], item.frame_byte};
    else if (pos == 6'd36 || pos == 6'd37) dp_n = {destination_port[7:0], item.frame_byte};
  end

  logic [6:0] len;
  assign len = {1'b0, pos} + 7'd1;

  always_ff @(posedge clk) begin
    result_strobe <= 1'b0;
    if (rst) begin
      state <= S_CLEAR;
      byte_position <= '0; ether_kind <= '0; ip_protocol <= '0;
      source_address <= '0; destination_port <= '0;
      tbl <= TBL_BLOCK; key_frame <= 1'b0; cur_op <= OP_FRAME;
    end else begin
      case (state)
        S_CLEAR: if (stat.clear_done) state <= S_IDLE;
        S_IDLE: if (acc) begin
          key_addr <= item.ip_address;
          key_port <= item.tcp_port;
          cur_op   <= item.op;
          key_frame <= item.op == OP_FRAME;
          if (item.op == OP_FRAME) begin
            if (item.frame_end && (len < 7'(IP_MIN) || ek_n != KIND_IPV4)) begin
              result_strobe <= 1'b1;
              result <= '0;
              byte_position <= '0; ether_kind <= '0; ip_protocol <= '0;
              source_address <= '0; destination_port <= '0;
            end else begin
              if (pos < POS_MAX) byte_position <= pos + 1'b1;
              ether_kind <= ek_n; ip_protocol <= pr_n;
              source_address <= sa_n; destination_port <= dp_n;
              if (item.frame_end) begin
                frame_len_tcp <= len >= 7'(TCP_MIN);
                tbl <= TBL_BLOCK; state <= S_KICK;
              end
            end
          end else if (item.op != OP_UNUSED) begin
            case (item.op)
              OP_BLOCK_ADD, OP_BLOCK_REM: tbl <= TBL_BLOCK;
              OP_PORT_ADD, OP_PORT_REM:   tbl <= TBL_PORT;
              default:                    tbl <= TBL_ALLOW;
            endcase
            state <= S_KICK;
          end
        end
        S_KICK: state <= S_SCAN;
        S_SCAN: if (stat.scan_done) begin
          if (cur_op == OP_FRAME) begin
            if (decide_now) begin
              result_strobe <= 1'b1;
              result.result_kind <= 1'b0;
              result.table_status <= ST_DONE;
              result.verdict <= (tbl == TBL_BLOCK) ? stat.hit :
                                (tbl == TBL_ALLOW) ? !stat.hit : 1'b0;
              byte_position <= '0; ether_kind <= '0; ip_protocol <= '0;
              source_address <= '0; destination_port <= '0;
              state <= S_IDLE;
            end else begin
              tbl <= (tbl == TBL_BLOCK) ? TBL_PORT : TBL_ALLOW;
              state <= S_KICK;
            end
          end else state <= S_WRITE;
        end
        S_WRITE: begin
          result_strobe <= 1'b1;
          result.result_kind <= 1'b1;
          result.verdict <= 1'b0;
          if (cur_op == OP_BLOCK_ADD || cur_op == OP_PORT_ADD || cur_op == OP_ALLOW_ADD)
            result.table_status <= (stat.hit || stat.free_found) ? ST_DONE : ST_FULL;
          else
            result.table_status <= stat.hit ? ST_DONE : ST_ABSENT;
          state <= S_IDLE;
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  `ASSERT_NEXT(a_kick_scan, clk, rst, state == S_KICK, state == S_SCAN, "kick not followed by scan")
  `ASSERT_IMPL(a_strobe_idle, clk, rst, result_strobe, state == S_IDLE, "strobe outside idle")
  `ASSERT_IMPL(a_one_cmd, clk, rst, 1'b1, $onehot0({cmd.scan_start, cmd.do_insert, cmd.do_remove, cmd.clear_step}), "conflicting commands")
endmodule

// ----- hw/rtl/packet_source_port_acl_filter_core.sv -----
// Packet source / port ACL filter.
// Input: item (op, frame_byte, frame_end, ip_address, tcp_port) is transferred
// on a rising edge where start is high and busy is low.
// Output: result_strobe marks one cycle carrying result; the receiver must take
// it then, it cannot stall the block.
// Frame bytes without frame_end give no result.
// A frame end with no table check gives its verdict the next cycle.
// Otherwise the block scans the tables with one memory read per cycle:
// block table first, then port table and allow table when the rules reach
// them; a table op scans one table then writes.
// The scan stops early on a key hit.
// Reset: synchronous, rst high. After rst falls, a clearing pass walks all
// three tables, one entry per cycle, with busy high; frame capture registers
// return to zero.
// One transfer at a time; the tables' single read port sets the rate.
module packet_source_port_acl_filter_core import psacl_pkg::*; #(
  parameter int BLOCK_ENTRIES = 1024,
  parameter int PORT_ENTRIES  = 256,
  parameter int ALLOW_ENTRIES = 1024
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  in_item_t  item,
  output logic      busy,
  output logic      result_strobe,
  output out_item_t result
);
  dp_cmd_t     cmd;
  dp_stat_t    stat;
  logic [31:0] key_addr, frm_addr;
  logic [15:0] key_port, frm_port;

  psacl_controller u_ctrl (
    .clk, .rst, .start, .item, .stat, .busy, .cmd,
    .key_addr, .key_port, .frm_addr, .frm_port, .result_strobe, .result
  );

  psacl_datapath #(
    .BLOCK_ENTRIES(BLOCK_ENTRIES), .PORT_ENTRIES(PORT_ENTRIES),
    .ALLOW_ENTRIES(ALLOW_ENTRIES)
  ) u_dp (
    .clk, .rst, .cmd, .key_addr, .key_port, .frm_addr, .frm_port, .stat
  );
endmodule
